### rtl/core/assert_macros.svh
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising edge of clk, off while rst_n is low.
`define CHT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("cht_checker: check failed");

// Same check with a message of its own.
`define CHT_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

`endif

### rtl/core/cht_pkg.sv
// Constants, codes and types of the coalesced hash table.
package cht_pkg;

  localparam int TABLE_SIZE = 16;
  localparam int KEY_BITS   = 10;

  localparam int SLOT_BITS = $clog2(TABLE_SIZE);
  localparam int LINK_BITS = $clog2(TABLE_SIZE + 1);
  localparam int CNT_BITS  = LINK_BITS;
  localparam bit TS_POW2   = (TABLE_SIZE == (1 << SLOT_BITS));

  // Field widths on the stream ports.
  localparam int CMD_W    = 2;
  localparam int KEY_W    = 10;
  localparam int ID_W     = 31;
  localparam int NAME_W   = 56;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 4;
  localparam int PROBE_W  = 5;

  localparam int IN_DATA_W  = ((CMD_W + KEY_W + ID_W + NAME_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((STATUS_W + SLOT_W + ID_W + NAME_W + PROBE_W + 7) / 8) * 8;

  localparam logic [LINK_BITS-1:0] LINK_NONE = LINK_BITS'(TABLE_SIZE);

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_INSERTED = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_FOUND    = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_MISSING  = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_CLEARED  = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HASH,
    S_RD,
    S_CHK,
    S_FILL,
    S_LINK,
    S_RESP
  } fsm_state_t;

  typedef struct packed {
    logic [NAME_W-1:0] name;
    logic [ID_W-1:0]   id;
    logic [KEY_W-1:0]  key;
    logic [CMD_W-1:0]  cmd;
  } item_t;

  typedef struct packed {
    logic [PROBE_W-1:0]  probes;
    logic [NAME_W-1:0]   name;
    logic [ID_W-1:0]     id;
    logic [SLOT_W-1:0]   slot;
    logic [STATUS_W-1:0] status;
  } result_t;

  typedef struct packed {
    logic [NAME_W-1:0]    name;
    logic [ID_W-1:0]      id;
    logic [LINK_BITS-1:0] link;
    logic [KEY_BITS-1:0]  key;
  } entry_t;

  typedef struct packed {
    logic                start;
    logic [KEY_BITS-1:0] key;
  } hash_req_t;

  typedef struct packed {
    logic                 done;
    logic [SLOT_BITS-1:0] home;
  } hash_rsp_t;

  typedef struct packed {
    logic                 we;
    logic [SLOT_BITS-1:0] waddr;
    entry_t               wdata;
    logic                 re;
    logic [SLOT_BITS-1:0] raddr;
  } mem_req_t;

endpackage

### rtl/core/coalesced_hash_table.sv
// Top level of the coalesced chaining hash table with its output register.
//
// Commands arrive on the in_ stream (insert, search, clear); every insert,
// search or clear gives exactly one result transfer on the out_ stream.
// The unused command code is taken and dropped without a result.
// Items are worked one at a time. A clear goes straight to its result;
// an insert or search first gets its home slot from the hash unit, which
// for a power-of-two table size keeps the low key bits and otherwise
// takes a quotient step and a remainder step. The chain walk reads each
// slot through the single read port of the entry RAM: the address goes
// out in S_RD and the data is checked in S_CHK. The block passes through
// the idle state after each result before it takes the next command.
// Reset empties the table at once: the used flags clear and the RAM needs
// no sweep. While the receiver stalls, the finished result waits in the
// output register; the block still takes and completes one more command,
// which then waits until the register frees up.
module coalesced_hash_table (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // cmd[1:0], key[11:2], student_id[42:12], name_packed[98:43], zero fill
  input  logic [cht_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // status[2:0], slot[6:3], found_id[37:7], found_name[93:38],
  // probe_count[98:94], zero fill
  output logic [cht_pkg::OUT_DATA_W-1:0]   out_tdata
);

  cht_pkg::item_t      in_item;
  cht_pkg::hash_req_t  hash_req;
  cht_pkg::hash_rsp_t  hash_rsp;
  cht_pkg::mem_req_t   mem_req;
  cht_pkg::entry_t     mem_rdata;
  cht_pkg::result_t    res;
  logic                res_valid;
  logic                res_ready;

  logic                out_valid_r, out_valid_nxt;
  cht_pkg::result_t    out_res_r, out_res_nxt;

  assign in_item = in_tdata[$bits(cht_pkg::item_t)-1:0];

  cht_hash u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (hash_req),
    .rsp   (hash_rsp)
  );

  cht_ram #(
    .WIDTH ($bits(cht_pkg::entry_t)),
    .DEPTH (cht_pkg::TABLE_SIZE)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

  cht_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_item   (in_item),
    .hash_req  (hash_req),
    .hash_rsp  (hash_rsp),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = cht_pkg::OUT_DATA_W'(out_res_r);

endmodule

### rtl/core/cht_ram.sv
// Generic simple dual-port RAM with a registered read port.
module cht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/cht_hash.sv
// Home slot: key mod table size, low bits or by reciprocal multiplication.
module cht_hash (
  input  logic                clk,
  input  logic                rst_n,
  input  cht_pkg::hash_req_t  req,
  output cht_pkg::hash_rsp_t  rsp
);

  localparam int KB     = cht_pkg::KEY_BITS;
  localparam int SB     = cht_pkg::SLOT_BITS;
  localparam int SHIFT  = KB + SB;
  localparam int PROD_W = SHIFT + KB + 1;
  // Rounded-up reciprocal of the table size; it gives the exact quotient
  // for every key of KB bits.
  localparam logic [KB:0] RECIP = (KB + 1)'(((64'd1 << SHIFT) +
      64'(cht_pkg::TABLE_SIZE) - 64'd1) / 64'(cht_pkg::TABLE_SIZE));

  logic                 busy_r, busy_nxt;
  logic [1:0]           cnt_r, cnt_nxt;
  logic [KB-1:0]        key_r, key_nxt;
  logic [KB:0]          quo_r, quo_nxt;
  logic [SB-1:0]        rem_r, rem_nxt;
  logic [PROD_W-1:0]    prod;
  logic [KB-1:0]        diff;
  logic                 done;

  assign done = busy_r && (cnt_r == '0);
  assign prod = PROD_W'(key_r) * PROD_W'(RECIP);
  assign diff = key_r - KB'(quo_r) * KB'(cht_pkg::TABLE_SIZE);

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    key_nxt  = key_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      key_nxt  = req.key;
      if (cht_pkg::TS_POW2) begin
        // A power-of-two size only keeps the low key bits.
        cnt_nxt = '0;
        rem_nxt = SB'(req.key);
      end else begin
        cnt_nxt = 2'd2;
      end
    end else if (done) begin
      busy_nxt = 1'b0;
    end else if (busy_r) begin
      cnt_nxt = cnt_r - 1'b1;
      // First the quotient, then the key minus quotient times table size.
      if (cnt_r == 2'd2) begin
        quo_nxt = prod[SHIFT +: KB + 1];
      end else begin
        rem_nxt = SB'(diff);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    key_r <= key_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done = done;
  assign rsp.home = rem_r;

endmodule

### rtl/core/cht_ctrl.sv
// Command sequencer: used flags, chain walk and read-modify-write of the entry RAM.
module cht_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  cht_pkg::item_t      in_item,
  output cht_pkg::hash_req_t  hash_req,
  input  cht_pkg::hash_rsp_t  hash_rsp,
  output cht_pkg::mem_req_t   mem_req,
  input  cht_pkg::entry_t     mem_rdata,
  output logic                res_valid,
  input  logic                res_ready,
  output cht_pkg::result_t    res
);

  localparam int SB = cht_pkg::SLOT_BITS;
  localparam int TS = cht_pkg::TABLE_SIZE;

  cht_pkg::fsm_state_t              state_r, state_nxt;
  logic [cht_pkg::CMD_W-1:0]        cmd_r, cmd_nxt;
  logic [cht_pkg::KEY_BITS-1:0]     key_r, key_nxt;
  logic [cht_pkg::ID_W-1:0]         id_r, id_nxt;
  logic [cht_pkg::NAME_W-1:0]       name_r, name_nxt;
  logic [TS-1:0]                    used_r, used_nxt;
  logic [SB-1:0]                    cur_r, cur_nxt;
  logic [SB-1:0]                    tgt_r, tgt_nxt;
  logic [cht_pkg::CNT_BITS-1:0]     cnt_r, cnt_nxt;
  logic                             link_pend_r, link_pend_nxt;
  cht_pkg::result_t                 res_r, res_nxt;

  logic                             in_acc;
  logic                             is_insert;
  logic                             free_found;
  logic [SB-1:0]                    free_slot;
  logic                             cur_used;
  logic [cht_pkg::LINK_BITS-1:0]    walk_link;
  logic                             link_end;
  logic                             cnt_max;
  logic                             key_hit;
  logic                             home_used;

  assign in_acc    = in_valid && (state_r == cht_pkg::S_IDLE);
  assign is_insert = (cmd_r == cht_pkg::CMD_INSERT);
  assign home_used = used_r[hash_rsp.home];
  assign cur_used  = used_r[cur_r];
  // An empty slot always ends a chain; its stored link may be stale.
  assign walk_link = cur_used ? mem_rdata.link : cht_pkg::LINK_NONE;
  assign link_end  = (walk_link >= cht_pkg::LINK_NONE);
  assign cnt_max   = (cnt_r == cht_pkg::CNT_BITS'(TS));
  assign key_hit   = cur_used && (mem_rdata.key == key_r);

  // Lowest-numbered empty slot.
  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = TS - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_found = 1'b1;
        free_slot  = SB'(i);
      end
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cht_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_item.cmd == cht_pkg::CMD_INSERT || in_item.cmd == cht_pkg::CMD_SEARCH) begin
            state_nxt = cht_pkg::S_HASH;
          end else if (in_item.cmd == cht_pkg::CMD_CLEAR) begin
            state_nxt = cht_pkg::S_RESP;
          end
        end
      end
      cht_pkg::S_HASH: begin
        if (hash_rsp.done) begin
          if (!is_insert) begin
            state_nxt = cht_pkg::S_RD;
          end else if (!home_used) begin
            state_nxt = cht_pkg::S_FILL;
          end else if (!free_found) begin
            state_nxt = cht_pkg::S_RESP;
          end else begin
            state_nxt = cht_pkg::S_RD;
          end
        end
      end
      cht_pkg::S_RD: begin
        state_nxt = cht_pkg::S_CHK;
      end
      cht_pkg::S_CHK: begin
        if (is_insert) begin
          state_nxt = (link_end || cnt_max) ? cht_pkg::S_FILL : cht_pkg::S_RD;
        end else begin
          state_nxt = (key_hit || link_end || cnt_max) ? cht_pkg::S_RESP : cht_pkg::S_RD;
        end
      end
      cht_pkg::S_FILL: begin
        state_nxt = link_pend_r ? cht_pkg::S_LINK : cht_pkg::S_RESP;
      end
      cht_pkg::S_LINK: begin
        state_nxt = cht_pkg::S_RESP;
      end
      cht_pkg::S_RESP: begin
        if (res_ready) begin
          state_nxt = cht_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = cht_pkg::S_IDLE;
      end
    endcase
  end

  // Working registers and the result.
  always_comb begin
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    id_nxt        = id_r;
    name_nxt      = name_r;
    used_nxt      = used_r;
    cur_nxt       = cur_r;
    tgt_nxt       = tgt_r;
    cnt_nxt       = cnt_r;
    link_pend_nxt = link_pend_r;
    res_nxt       = res_r;
    unique case (state_r)
      cht_pkg::S_IDLE: begin
        if (in_acc) begin
          cmd_nxt  = in_item.cmd;
          key_nxt  = cht_pkg::KEY_BITS'(in_item.key);
          id_nxt   = in_item.id;
          name_nxt = in_item.name;
          if (in_item.cmd == cht_pkg::CMD_CLEAR) begin
            used_nxt       = '0;
            res_nxt        = '0;
            res_nxt.status = cht_pkg::STAT_CLEARED;
          end
        end
      end
      cht_pkg::S_HASH: begin
        if (hash_rsp.done) begin
          cur_nxt = hash_rsp.home;
          res_nxt = '0;
          if (!is_insert) begin
            cnt_nxt = cht_pkg::CNT_BITS'(1);
          end else if (!home_used) begin
            tgt_nxt        = hash_rsp.home;
            link_pend_nxt  = 1'b0;
            res_nxt.status = cht_pkg::STAT_INSERTED;
            res_nxt.slot   = cht_pkg::SLOT_W'(hash_rsp.home);
          end else if (!free_found) begin
            res_nxt.status = cht_pkg::STAT_FULL;
          end else begin
            tgt_nxt        = free_slot;
            link_pend_nxt  = 1'b1;
            cnt_nxt        = '0;
            res_nxt.status = cht_pkg::STAT_INSERTED;
            res_nxt.slot   = cht_pkg::SLOT_W'(free_slot);
          end
        end
      end
      cht_pkg::S_CHK: begin
        if (is_insert) begin
          if (!(link_end || cnt_max)) begin
            cur_nxt = walk_link[SB-1:0];
            cnt_nxt = cnt_r + 1'b1;
          end
        end else if (key_hit) begin
          res_nxt.status = cht_pkg::STAT_FOUND;
          res_nxt.slot   = cht_pkg::SLOT_W'(cur_r);
          res_nxt.id     = mem_rdata.id;
          res_nxt.name   = mem_rdata.name;
          res_nxt.probes = cht_pkg::PROBE_W'(cnt_r);
        end else if (link_end || cnt_max) begin
          res_nxt.status = cht_pkg::STAT_MISSING;
          res_nxt.probes = cht_pkg::PROBE_W'(cnt_r);
        end else begin
          cur_nxt = walk_link[SB-1:0];
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      cht_pkg::S_FILL: begin
        used_nxt[tgt_r] = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready       = (state_r == cht_pkg::S_IDLE);
    res_valid      = (state_r == cht_pkg::S_RESP);
    hash_req.start = in_acc && (in_item.cmd == cht_pkg::CMD_INSERT ||
                                in_item.cmd == cht_pkg::CMD_SEARCH);
    hash_req.key   = cht_pkg::KEY_BITS'(in_item.key);
    mem_req.we     = 1'b0;
    mem_req.waddr  = tgt_r;
    mem_req.wdata  = '{name: name_r, id: id_r, link: cht_pkg::LINK_NONE, key: key_r};
    mem_req.re     = (state_r == cht_pkg::S_RD);
    mem_req.raddr  = cur_r;
    if (state_r == cht_pkg::S_FILL) begin
      mem_req.we = 1'b1;
    end else if (state_r == cht_pkg::S_LINK) begin
      // The tail word is still in the read register from the last walk step.
      mem_req.we         = 1'b1;
      mem_req.waddr      = cur_r;
      mem_req.wdata      = mem_rdata;
      mem_req.wdata.link = cht_pkg::LINK_BITS'(tgt_r);
    end
  end

  assign res = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cht_pkg::S_IDLE;
      used_r  <= '0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
    end
    cmd_r       <= cmd_nxt;
    key_r       <= key_nxt;
    id_r        <= id_nxt;
    name_r      <= name_nxt;
    cur_r       <= cur_nxt;
    tgt_r       <= tgt_nxt;
    cnt_r       <= cnt_nxt;
    link_pend_r <= link_pend_nxt;
    res_r       <= res_nxt;
  end

endmodule

### rtl/core/cht_checker.sv
// Port-level checks of the coalesced hash table, bound to the top level.
`include "assert_macros.svh"

module cht_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic [cht_pkg::IN_DATA_W-1:0]  in_tdata,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [cht_pkg::OUT_DATA_W-1:0] out_tdata
);

  localparam int PROBE_LSB = cht_pkg::STATUS_W + cht_pkg::SLOT_W + cht_pkg::ID_W +
                             cht_pkg::NAME_W;

  logic [cht_pkg::STATUS_W-1:0] status;
  logic [cht_pkg::PROBE_W-1:0]  probes;
  logic [cht_pkg::CMD_W-1:0]    cmd;

  assign status = out_tdata[cht_pkg::STATUS_W-1:0];
  assign probes = out_tdata[PROBE_LSB +: cht_pkg::PROBE_W];
  assign cmd    = in_tdata[cht_pkg::CMD_W-1:0];

  `CHT_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid)

  `CHT_ASSERT_MSG(a_probe_zero, out_tvalid && status != cht_pkg::STAT_FOUND && status != cht_pkg::STAT_MISSING |-> probes == '0, "cht_checker: probe count on a non-search result")

  `CHT_ASSERT_MSG(a_found_probe, out_tvalid && status == cht_pkg::STAT_FOUND |-> probes != '0, "cht_checker: found entry without a probe")

  `CHT_ASSERT_MSG(a_busy_after_cmd, in_tvalid && in_tready && (cmd == cht_pkg::CMD_INSERT || cmd == cht_pkg::CMD_SEARCH || cmd == cht_pkg::CMD_CLEAR) |=> !in_tready, "cht_checker: command taken while another is in work")

endmodule

bind coalesced_hash_table cht_checker u_cht_checker (.*);

### verif/tb_coalesced_hash_table.sv
// Self-checking testbench for the coalesced chaining hash table.
`timescale 1ns / 1ps

module tb_coalesced_hash_table;

  localparam int NUM_ITEMS = 1200;
  localparam logic [cht_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [cht_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [cht_pkg::OUT_DATA_W-1:0] out_tdata;

  coalesced_hash_table i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Commands waiting to be sent and the replies the table must still give.
  cht_pkg::item_t   cmd_queue[$];
  cht_pkg::result_t pending_replies[$];
  int               error_count = 0;

  // Shadow copy of the slot array.
  logic                         tbl_used[cht_pkg::TABLE_SIZE];
  logic [cht_pkg::KEY_BITS-1:0] tbl_key[cht_pkg::TABLE_SIZE];
  int                           tbl_link[cht_pkg::TABLE_SIZE];
  logic [cht_pkg::ID_W-1:0]     tbl_id[cht_pkg::TABLE_SIZE];
  logic [cht_pkg::NAME_W-1:0]   tbl_name[cht_pkg::TABLE_SIZE];

  // Sender and receiver pacing.
  int burst_left = 1;
  int gap_left = 0;
  int rx_mode = 0;
  int rx_mode_left = 0;
  int rx_stall_left = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  task automatic empty_table();
    int i;
    for (i = 0; i < cht_pkg::TABLE_SIZE; i++) begin
      tbl_used[i] = 1'b0;
      tbl_key[i] = '0;
      tbl_link[i] = cht_pkg::TABLE_SIZE;
      tbl_id[i] = '0;
      tbl_name[i] = '0;
    end
  endtask

  task automatic fill_slot(input int s, input cht_pkg::item_t it);
    tbl_used[s] = 1'b1;
    tbl_key[s] = it.key[cht_pkg::KEY_BITS-1:0];
    tbl_link[s] = cht_pkg::TABLE_SIZE;
    tbl_id[s] = it.id;
    tbl_name[s] = it.name;
  endtask

  // Applies one accepted command to the shadow table and queues its reply, if it has one.
  task automatic apply_command(input cht_pkg::item_t it);
    cht_pkg::result_t             r;
    logic [cht_pkg::KEY_BITS-1:0] k;
    int                           home;
    int                           free_slot;
    int                           tail;
    int                           cur;
    int                           probes;
    int                           i;
    r = '0;
    k = it.key[cht_pkg::KEY_BITS-1:0];
    home = int'(k) % cht_pkg::TABLE_SIZE;
    case (it.cmd)
      cht_pkg::CMD_INSERT: begin
        if (!tbl_used[home]) begin
          fill_slot(home, it);
          r.status = cht_pkg::STAT_INSERTED;
          r.slot = cht_pkg::SLOT_W'(home);
        end else begin
          free_slot = cht_pkg::TABLE_SIZE;
          for (i = cht_pkg::TABLE_SIZE - 1; i >= 0; i--) begin
            if (!tbl_used[i]) free_slot = i;
          end
          if (free_slot == cht_pkg::TABLE_SIZE) begin
            r.status = cht_pkg::STAT_FULL;
          end else begin
            tail = home;
            for (i = 0; i < cht_pkg::TABLE_SIZE; i++) begin
              if (tbl_link[tail] >= cht_pkg::TABLE_SIZE) break;
              tail = tbl_link[tail];
            end
            fill_slot(free_slot, it);
            tbl_link[tail] = free_slot;
            r.status = cht_pkg::STAT_INSERTED;
            r.slot = cht_pkg::SLOT_W'(free_slot);
          end
        end
      end
      cht_pkg::CMD_SEARCH: begin
        cur = home;
        probes = 1;
        r.status = cht_pkg::STAT_MISSING;
        forever begin
          if (tbl_used[cur] && tbl_key[cur] == k) begin
            r.status = cht_pkg::STAT_FOUND;
            r.slot = cht_pkg::SLOT_W'(cur);
            r.id = tbl_id[cur];
            r.name = tbl_name[cur];
            break;
          end
          if (tbl_link[cur] >= cht_pkg::TABLE_SIZE || probes >= cht_pkg::TABLE_SIZE) break;
          cur = tbl_link[cur];
          probes++;
        end
        r.probes = cht_pkg::PROBE_W'(probes);
      end
      cht_pkg::CMD_CLEAR: begin
        empty_table();
        r.status = cht_pkg::STAT_CLEARED;
      end
      default: return;
    endcase
    pending_replies.push_back(r);
  endtask

  task automatic push_cmd(input logic [cht_pkg::CMD_W-1:0] c, input int k,
                          input logic [cht_pkg::ID_W-1:0] id,
                          input logic [cht_pkg::NAME_W-1:0] name);
    cht_pkg::item_t it;
    it.cmd = c;
    it.key = cht_pkg::KEY_W'(k);
    it.id = id;
    it.name = name;
    cmd_queue.push_back(it);
  endtask

  function automatic logic [cht_pkg::ID_W-1:0] rand_id();
    return cht_pkg::ID_W'($urandom);
  endfunction

  function automatic logic [cht_pkg::NAME_W-1:0] rand_name();
    return cht_pkg::NAME_W'({$urandom, $urandom});
  endfunction

  // Stimulus: a directed opening, then random traffic, then the drain.
  initial begin
    int live_keys[$];
    int homes[3];
    int sent;
    int roll;
    int k;
    int j;
    empty_table();

    push_cmd(cht_pkg::CMD_SEARCH, 0, rand_id(), rand_name());   // empty home slot
    push_cmd(cht_pkg::CMD_INSERT, 0, '0, '0);
    push_cmd(cht_pkg::CMD_INSERT, 16, rand_id(), rand_name());  // collides with key 0
    push_cmd(cht_pkg::CMD_INSERT, 16, rand_id(), rand_name());  // duplicate key
    push_cmd(cht_pkg::CMD_SEARCH, 16, rand_id(), rand_name());
    push_cmd(cht_pkg::CMD_SEARCH, 0, rand_id(), rand_name());
    push_cmd(CMD_UNUSED, 1023, '1, '1);                         // unused code, no reply
    // Grow one chain across every remaining slot, then overflow the table.
    for (j = 0; j < 13; j++) begin
      push_cmd(cht_pkg::CMD_INSERT, 32 + 16 * j, rand_id(), rand_name());
    end
    push_cmd(cht_pkg::CMD_INSERT, 1023, rand_id(), rand_name());
    push_cmd(cht_pkg::CMD_SEARCH, 240, rand_id(), rand_name()); // walk stops at table size
    push_cmd(cht_pkg::CMD_CLEAR, 0, rand_id(), rand_name());
    push_cmd(cht_pkg::CMD_INSERT, 1023, '1, '1);
    push_cmd(cht_pkg::CMD_SEARCH, 1023, '0, '0);

    sent = 0;
    for (j = 0; j < 3; j++) homes[j] = $urandom_range(0, cht_pkg::TABLE_SIZE - 1);
    while (sent < NUM_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
        roll = $urandom_range(0, 9);
        if (roll < 5)
          k = homes[$urandom_range(0, 2)] + cht_pkg::TABLE_SIZE * $urandom_range(0, 63);
        else if (roll < 7 && live_keys.size() > 0)
          k = live_keys[$urandom_range(0, live_keys.size() - 1)];
        else
          k = $urandom_range(0, 1023);
        live_keys.push_back(k);
        push_cmd(cht_pkg::CMD_INSERT, k, rand_id(), rand_name());
        sent++;
      end else if (roll < 94) begin
        roll = $urandom_range(0, 9);
        if (roll < 7 && live_keys.size() > 0)
          k = live_keys[$urandom_range(0, live_keys.size() - 1)];
        else if (roll < 9)
          k = homes[$urandom_range(0, 2)] + cht_pkg::TABLE_SIZE * $urandom_range(0, 63);
        else
          k = $urandom_range(0, 1023);
        push_cmd(cht_pkg::CMD_SEARCH, k, rand_id(), rand_name());
        sent++;
      end else if (roll < 97) begin
        live_keys.delete();
        for (j = 0; j < 3; j++) homes[j] = $urandom_range(0, cht_pkg::TABLE_SIZE - 1);
        push_cmd(cht_pkg::CMD_CLEAR, $urandom_range(0, 1023), rand_id(), rand_name());
        sent++;
      end else begin
        push_cmd(CMD_UNUSED, $urandom_range(0, 1023), rand_id(), rand_name());
      end
    end

    while (cmd_queue.size() != 0 || in_tvalid) @(posedge clk);
    while (pending_replies.size() != 0) @(posedge clk);
    // Leave room for a stray reply after the last expected one.
    repeat (60) @(posedge clk);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Sender: bursts of transfers separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        apply_command(cht_pkg::item_t'(in_tdata[$bits(cht_pkg::item_t)-1:0]));
        void'(cmd_queue.pop_front());
      end
      if (in_tvalid && !in_tready) begin
        // Hold the current transfer until it is taken.
      end else if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (cmd_queue.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tdata <= cht_pkg::IN_DATA_W'(cmd_queue[0]);
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          case ($urandom_range(0, 3))
            0, 1: gap_left = 0;
            2: gap_left = $urandom_range(1, 6);
            default: gap_left = $urandom_range(10, 40);
          endcase
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: switches among always ready, random ready and long stalls.
  always @(posedge clk) begin
    logic rdy;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        rx_mode_left = $urandom_range(20, 120);
      end else begin
        rx_mode_left--;
      end
      case (rx_mode)
        0: rdy = 1'b1;
        1: rdy = ($urandom_range(0, 99) < 60);
        default: begin
          if (rx_stall_left > 0) begin
            rx_stall_left--;
            rdy = 1'b0;
          end else begin
            rdy = 1'b1;
            if ($urandom_range(0, 9) == 0) rx_stall_left = $urandom_range(5, 40);
          end
        end
      endcase
      out_tready <= rdy;
    end
  end

  // Result checker.
  always @(posedge clk) begin
    cht_pkg::result_t got;
    cht_pkg::result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = cht_pkg::result_t'(out_tdata[$bits(cht_pkg::result_t)-1:0]);
      if (pending_replies.size() == 0) begin
        $error("result transfer with none expected: status %0d slot %0d",
               got.status, got.slot);
        error_count++;
      end else begin
        want = pending_replies.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, got.status);
          error_count++;
        end
        if (got.slot !== want.slot) begin
          $error("slot: expected %0d, actual %0d", want.slot, got.slot);
          error_count++;
        end
        if (got.id !== want.id) begin
          $error("found_id: expected %0h, actual %0h", want.id, got.id);
          error_count++;
        end
        if (got.name !== want.name) begin
          $error("found_name: expected %0h, actual %0h", want.name, got.name);
          error_count++;
        end
        if (got.probes !== want.probes) begin
          $error("probe_count: expected %0d, actual %0d", want.probes, got.probes);
          error_count++;
        end
      end
    end
  end

endmodule
